[hdl/rxm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxm_pkg
// Shared types and constants of the streaming pattern matcher.
// ----------------------------------------------------------------------------
package rxm_pkg;

   localparam int CHAR_W    = 8;
   localparam int PAT_CHARS = 16;
   localparam int PAT_W     = PAT_CHARS * CHAR_W;
   localparam int WORD_W    = 64;
   localparam int LEN_CFG_W = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;

   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LEN  = 2'd2;

   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_APPEND = 1'b1;

   typedef struct packed {
      logic                 command;
      logic [PAT_CHARS-1:0] hit;
   } rxm_item_type;

endpackage

[hdl/rxm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxm_front
// Classifies an incoming transaction: per pattern position, whether the
// pattern character matches the text byte.
// ----------------------------------------------------------------------------
module rxm_front (
   input  logic [rxm_pkg::PAT_W-1:0]  pattern,
   input  logic                       command,
   input  logic [rxm_pkg::CHAR_W-1:0] text_char,
   output rxm_pkg::rxm_item_type      item
);
   import rxm_pkg::*;

   always_comb begin
      item.command = command;
      for (int k = 0; k < PAT_CHARS; k++) begin
         item.hit[k] = (pattern[k*CHAR_W +: CHAR_W] == text_char) ||
                       (pattern[k*CHAR_W +: CHAR_W] == CH_DOT);
      end
   end

endmodule

[hdl/rxm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxm_queue
// Two-entry queue between the classify front and the column back end.
// ----------------------------------------------------------------------------
module rxm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rxm_pkg::rxm_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  out_valid,
   output rxm_pkg::rxm_item_type out_item
);
   import rxm_pkg::*;

   localparam int DEPTH   = 2;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   rxm_item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == COUNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> out_valid)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

[hdl/rxm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxm_back
// Holds the match column, advances it by one queued transaction per cycle
// while rsp_stall holds no result, and keeps the result in an output register.
// ----------------------------------------------------------------------------
module rxm_back #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rxm_pkg::PAT_W-1:0]     pattern,
   input  logic [rxm_pkg::LEN_CFG_W-1:0] pattern_length,
   input  logic                          item_valid,
   input  rxm_pkg::rxm_item_type         item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_matched
);
   import rxm_pkg::*;

   localparam int COL_W = MAX_PATTERN + 1;
   localparam int LEN_W = $clog2(COL_W);

   logic [COL_W-1:0]     column_ff;
   logic [COL_W-1:0]     col_next;
   logic [LEN_W-1:0]     used_len;
   logic [PAT_CHARS-1:0] star_vec;
   logic [PAT_CHARS-1:0] plus_vec;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_matched_ff;

   assign used_len = (pattern_length > LEN_CFG_W'(MAX_PATTERN)) ?
                     LEN_W'(MAX_PATTERN) : pattern_length[LEN_W-1:0];

   always_comb begin
      for (int k = 0; k < PAT_CHARS; k++) begin
         star_vec[k] = (pattern[k*CHAR_W +: CHAR_W] == CH_STAR);
         plus_vec[k] = (pattern[k*CHAR_W +: CHAR_W] == CH_PLUS);
      end
   end

   // one column step, chained through the lower bits like a carry
   always_comb begin
      col_next = '0;
      if (item.command == CMD_START) begin
         col_next[0] = 1'b1;
         for (int j = 2; j <= MAX_PATTERN; j++) begin
            col_next[j] = (j <= int'(used_len)) && star_vec[j-1] && col_next[j-2];
         end
      end else begin
         col_next[1] = (used_len != '0) && !star_vec[0] && !plus_vec[0] &&
                       item.hit[0] && column_ff[0];
         for (int j = 2; j <= MAX_PATTERN; j++) begin
            if (j <= int'(used_len)) begin
               if (star_vec[j-1]) begin
                  col_next[j] = col_next[j-2] | (item.hit[j-2] & column_ff[j]);
               end else if (plus_vec[j-1]) begin
                  col_next[j] = item.hit[j-2] & (col_next[j-1] | column_ff[j]);
               end else begin
                  col_next[j] = item.hit[j-1] & column_ff[j-1];
               end
            end
         end
      end
   end

   assign pop          = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= COL_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            column_ff <= col_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_matched_ff <= col_next[used_len];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   a_reset_column: assert property (@(posedge clock)
      reset |=> (column_ff == COL_W'(1)))
      else $error("column not reloaded by reset");

   a_pop_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped transaction without result");

   a_start_bit0: assert property (@(posedge clock) disable iff (reset)
      (pop && (item.command == CMD_START)) |=> column_ff[0])
      else $error("start did not set empty-prefix bit");

   a_append_bit0: assert property (@(posedge clock) disable iff (reset)
      (pop && (item.command == CMD_APPEND)) |=> !column_ff[0])
      else $error("append left empty-prefix bit set");

endmodule

[hdl/regex_match_dot_star_plus.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regex_match_dot_star_plus
// Streaming matcher of a text against a pattern with '.', '*' and '+'.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  req       req_valid/req_stall   req_command, req_text_char
//  rsp       rsp_valid/rsp_stall   rsp_matched
//  csr       csr_valid/csr_ready   csr_index, csr_wdata
//
//  one transaction per cycle unless stalled; result queued, then registered
//  rate set by the column update in the back end
//  reset clears pattern registers and loads the empty-text column
//  req_stall rises when the two-entry queue is full; rsp_stall holds the result
// ----------------------------------------------------------------------------
module regex_match_dot_star_plus #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [rxm_pkg::CHAR_W-1:0]    req_text_char,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_matched,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rxm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rxm_pkg::WORD_W-1:0]    csr_wdata
);
   import rxm_pkg::*;

   logic [WORD_W-1:0]    pat_low_ff;
   logic [WORD_W-1:0]    pat_high_ff;
   logic [LEN_CFG_W-1:0] pat_len_ff;
   logic [PAT_W-1:0]     pattern;
   rxm_item_type         front_item;
   rxm_item_type         queue_item;
   logic                 queue_full;
   logic                 queue_valid;
   logic                 push;
   logic                 pop;

   assign csr_ready = 1'b1;
   assign pattern   = {pat_high_ff, pat_low_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PAT_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PAT_HIGH: pat_high_ff <= csr_wdata;
            CSR_PAT_LEN:  pat_len_ff  <= csr_wdata[LEN_CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !req_stall;

   rxm_front u_front (
      .pattern   (pattern),
      .command   (req_command),
      .text_char (req_text_char),
      .item      (front_item)
   );

   rxm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (pop),
      .out_valid (queue_valid),
      .out_item  (queue_item)
   );

   rxm_back #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pattern        (pattern),
      .pattern_length (pat_len_ff),
      .item_valid     (queue_valid),
      .item           (queue_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_matched    (rsp_matched)
   );

endmodule
